[rtl/running_median_two_heaps_unit_macros.svh]
// Assertion macros shared by the running median checker.
// Pure text macros; no dependencies.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_UNIT_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RMED_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RMED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rmed_pkg.sv]
// Package for the running median unit: sizes, word types and chain control.
// No dependencies.
package rmed_pkg;

  // Most samples held at once.
  localparam int CAPACITY = 1024;
  // Cells in each chain; half the capacity plus one, room for an insert before the rebalance.
  localparam int CHAIN_DEPTH = CAPACITY / 2 + 1;
  // Width of a chain fill count.
  localparam int CNT_W = $clog2(CHAIN_DEPTH + 1);
  // Width of the sum of both fill counts.
  localparam int HELD_W = CNT_W + 1;

  // Field widths of the stream items.
  localparam int SAMPLE_W = 32;
  localparam int MED_W = 33;
  localparam int SCOUNT_W = 11;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W = OUT_DATA_W - MED_W - SCOUNT_W;

  typedef logic signed [SAMPLE_W-1:0] word_t;

  // Operation applied to a chain.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_POP
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    word_t     value;
  } chain_ctl_t;

endpackage

[rtl/rmed_cell.sv]
// One cell of a sorted chain: holds one word, kept in descending order.
// Depends on rmed_pkg.
module rmed_cell (
  input  logic                clk,
  input  rmed_pkg::chain_ctl_t ctl,
  input  logic                occ,
  input  logic                left_pass,
  input  rmed_pkg::word_t     left_word,
  input  rmed_pkg::word_t     right_word,
  output rmed_pkg::word_t     word,
  output logic                pass
);

  // The inserted word goes below this cell when this cell is held and not smaller.
  assign pass = occ && (word >= ctl.value);

  // Insert: keep, take the new word, or take the left neighbor's word.
  // Pop: take the right neighbor's word.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      rmed_pkg::OP_INS: begin
        if (!pass) begin
          word <= left_pass ? ctl.value : left_word;
        end
      end
      rmed_pkg::OP_POP: begin
        word <= right_word;
      end
      default: begin
        word <= word;
      end
    endcase
  end

endmodule

[rtl/rmed_chain.sv]
// Row of cells forming a descending sorted list with a fill count.
// Depends on rmed_pkg and rmed_cell.
module rmed_chain (
  input  logic                        clk,
  input  logic                        rst,
  input  rmed_pkg::chain_ctl_t        ctl,
  output rmed_pkg::word_t             top,
  output logic [rmed_pkg::CNT_W-1:0]  count
);

  rmed_pkg::word_t words [rmed_pkg::CHAIN_DEPTH];
  logic            passes [rmed_pkg::CHAIN_DEPTH];

  // Cells, each linked to its two neighbors.
  for (genvar i = 0; i < rmed_pkg::CHAIN_DEPTH; i++) begin : g_cell
    logic            occ;
    logic            left_pass;
    rmed_pkg::word_t left_word;
    rmed_pkg::word_t right_word;

    assign occ = (count > rmed_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_pass = 1'b1;
      assign left_word = ctl.value;
    end else begin : g_body
      assign left_pass = passes[i-1];
      assign left_word = words[i-1];
    end

    if (i == rmed_pkg::CHAIN_DEPTH - 1) begin : g_tail
      assign right_word = words[i];
    end else begin : g_inner
      assign right_word = words[i+1];
    end

    rmed_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occ        (occ),
      .left_pass  (left_pass),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[i]),
      .pass       (passes[i])
    );
  end

  assign top = words[0];

  // Fill count follows the operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctl.op)
        rmed_pkg::OP_INS: count <= count + 1'b1;
        rmed_pkg::OP_POP: count <= count - 1'b1;
        default:          count <= count;
      endcase
    end
  end

endmodule

[rtl/running_median_two_heaps_unit.sv]
// Running median of a stream of signed 32-bit samples, reported doubled.
// The lower half of the samples sits in one sorted chain of cells, largest first;
// the upper half sits in a second chain holding inverted words, so its head is the
// smallest upper sample. Each input item goes from acceptance to a loaded result
// through accept, insert, rebalance and result load, or through accept and result
// load alone when the store is full and the sample is dropped; the insert and the
// rebalance each update the cell chains, and the result load waits on a stalled
// output. A result register separates the output side, so a new item is accepted
// while the previous result waits. No clearing pass is needed after reset.
// Depends on rmed_pkg and rmed_chain.
module running_median_two_heaps_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rmed_pkg::SAMPLE_W-1:0]     s_axis_tdata,  // [31:0] sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [32:0] median_doubled, [43:33] sample_count, [47:44] zero
  output logic [rmed_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser   // [0] dropped
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_BAL,
    ST_FIN
  } state_t;

  state_t                        state;
  rmed_pkg::word_t               sample_q;
  logic                          dropped_q;

  rmed_pkg::chain_ctl_t          lower_ctl;
  rmed_pkg::chain_ctl_t          upper_ctl;
  rmed_pkg::word_t               lower_top;
  rmed_pkg::word_t               upper_raw;
  rmed_pkg::word_t               upper_top;
  logic [rmed_pkg::CNT_W-1:0]    lower_count;
  logic [rmed_pkg::CNT_W-1:0]    upper_count;
  logic [rmed_pkg::HELD_W-1:0]   held;
  logic                          full;
  logic                          to_lower;
  logic signed [rmed_pkg::MED_W-1:0] med;
  logic                          out_free;

  rmed_chain u_lower (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lower_ctl),
    .top   (lower_top),
    .count (lower_count)
  );

  rmed_chain u_upper (
    .clk   (clk),
    .rst   (rst),
    .ctl   (upper_ctl),
    .top   (upper_raw),
    .count (upper_count)
  );

  // The upper chain stores inverted words; inversion reverses signed order.
  assign upper_top = ~upper_raw;

  // Held count and store-full test.
  assign held = rmed_pkg::HELD_W'(lower_count) + rmed_pkg::HELD_W'(upper_count);
  assign full = (held >= rmed_pkg::HELD_W'(rmed_pkg::CAPACITY));

  // A sample joins the lower half when both halves are empty or it is at most the lower top.
  assign to_lower = ((lower_count == '0) && (upper_count == '0)) ||
                    ((lower_count != '0) && (sample_q <= lower_top));

  // Chain operations for the insert and rebalance cycles.
  always_comb begin
    lower_ctl = '{op: rmed_pkg::OP_NONE, value: sample_q};
    upper_ctl = '{op: rmed_pkg::OP_NONE, value: ~sample_q};
    unique case (state)
      ST_INS: begin
        if (to_lower) begin
          lower_ctl = '{op: rmed_pkg::OP_INS, value: sample_q};
        end else begin
          upper_ctl = '{op: rmed_pkg::OP_INS, value: ~sample_q};
        end
      end
      ST_BAL: begin
        if ({1'b0, lower_count} == {1'b0, upper_count} + 2'd2) begin
          lower_ctl = '{op: rmed_pkg::OP_POP, value: lower_top};
          upper_ctl = '{op: rmed_pkg::OP_INS, value: ~lower_top};
        end else if ({1'b0, upper_count} == {1'b0, lower_count} + 1'b1) begin
          upper_ctl = '{op: rmed_pkg::OP_POP, value: upper_raw};
          lower_ctl = '{op: rmed_pkg::OP_INS, value: upper_top};
        end
      end
      default: begin
      end
    endcase
  end

  // Doubled median from the two heads.
  always_comb begin
    priority if (lower_count == '0) begin
      med = '0;
    end else if (lower_count == upper_count) begin
      med = rmed_pkg::MED_W'(lower_top) + rmed_pkg::MED_W'(upper_top);
    end else begin
      med = {lower_top, 1'b0};
    end
  end

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The result load in ST_FIN takes over the valid flag itself.
      if (m_axis_tvalid && m_axis_tready && (state != ST_FIN)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            sample_q  <= s_axis_tdata;
            dropped_q <= full;
            state     <= full ? ST_FIN : ST_INS;
          end
        end
        ST_INS: begin
          state <= ST_BAL;
        end
        ST_BAL: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {{rmed_pkg::OUT_PAD_W{1'b0}},
                              rmed_pkg::SCOUNT_W'(held), med};
            m_axis_tuser  <= dropped_q;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/rmed_checker.sv]
// Port-level checker for the running median unit, bound to the top level.
// Depends on rmed_pkg and running_median_two_heaps_unit_macros.svh.
`include "running_median_two_heaps_unit_macros.svh"

module rmed_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rmed_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser
);

  // A stalled result item holds its contents.
  `RMED_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // A dropped sample is only reported with a full store.
  `RMED_ASSERT_NOW(a_drop_full, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[43:33] == rmed_pkg::SCOUNT_W'(rmed_pkg::CAPACITY), "drop without full store")

  // Every result counts at least one held sample.
  `RMED_ASSERT_NOW(a_count_nonzero, clk, rst, m_axis_tvalid, m_axis_tdata[43:33] != '0, "result with empty store")

  // With an odd count the median is a single sample, so its double is even.
  `RMED_ASSERT_NOW(a_odd_even, clk, rst, m_axis_tvalid && m_axis_tdata[33], !m_axis_tdata[0], "odd count gave odd doubled median")

  // An accepted item keeps the input closed for at least the next cycle.
  `RMED_ASSERT_NEXT(a_in_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input open right after an accept")

endmodule

bind running_median_two_heaps_unit rmed_checker u_rmed_checker (.*);
